/* hdl/mhpd_pkg.sv */
// ----------------------------------------------------------------------------
// mhpd_pkg
// Types and constants shared by the packet deframer core and its finishing logic.
// ----------------------------------------------------------------------------
package mhpd_pkg;

  localparam int unsigned PktLen     = 10;
  localparam int unsigned BodyLen    = 9;
  localparam int unsigned PayloadLen = 7;
  localparam int unsigned CountW     = 4;

  localparam logic [CountW-1:0] CountMax = 4'd15;
  localparam logic [6:0]        Low7Mask = 7'h7f;

  typedef logic [7:0]        byte_t;
  typedef logic [CountW-1:0] count_t;

  // Outcome of the completion check, handed from the finishing logic.
  typedef struct packed {
    logic                   good;
    byte_t [PayloadLen-1:0] payload;
  } fin_t;

endpackage

/* hdl/mhpd_rx_if.sv */
// ----------------------------------------------------------------------------
// mhpd_rx_if
// Channel that carries one received byte per item.
// ----------------------------------------------------------------------------
interface mhpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hdl/mhpd_res_if.sv */
// ----------------------------------------------------------------------------
// mhpd_res_if
// Channel that carries one deframer result per item.
// ----------------------------------------------------------------------------
interface mhpd_res_if;
  logic       valid;
  logic       ready;
  logic       packet_done;
  logic       checksum_good;
  logic [6:0] module_id;
  logic [7:0] payload_0;
  logic [7:0] payload_1;
  logic [7:0] payload_2;
  logic [7:0] payload_3;
  logic [7:0] payload_4;
  logic [7:0] payload_5;
  logic [7:0] payload_6;

  modport source (
    output valid, input ready,
    output packet_done, output checksum_good, output module_id,
    output payload_0, output payload_1, output payload_2, output payload_3,
    output payload_4, output payload_5, output payload_6
  );
  modport sink (
    input valid, output ready,
    input packet_done, input checksum_good, input module_id,
    input payload_0, input payload_1, input payload_2, input payload_3,
    input payload_4, input payload_5, input payload_6
  );
endinterface

/* hdl/mhpd_finish.sv */
// ----------------------------------------------------------------------------
// mhpd_finish
// Checksum check and bit 7 restoration for a completed packet.
// ----------------------------------------------------------------------------
module mhpd_finish (
  input  mhpd_pkg::byte_t [mhpd_pkg::BodyLen-1:0] body_i,
  input  mhpd_pkg::byte_t                         chk_i,
  output mhpd_pkg::fin_t                          fin_o
);
  import mhpd_pkg::*;

  byte_t sum;

  always_comb begin
    sum = '0;
    for (int unsigned i = 0; i < BodyLen; i++) begin
      sum = sum + body_i[i];
    end
  end

  always_comb begin
    fin_o.good = ((sum[6:0] & Low7Mask) == (chk_i[6:0] & Low7Mask));
    for (int unsigned k = 0; k < PayloadLen; k++) begin
      fin_o.payload[k] = {body_i[1][k], body_i[k+2][6:0]};
    end
  end

endmodule

/* hdl/msb_head_packet_deframer_core.sv */
// ----------------------------------------------------------------------------
// msb_head_packet_deframer_core
// Finds ten-byte packets with a seven-bit ID and checksum in a byte stream.
// ----------------------------------------------------------------------------
// The block takes one received byte per item and returns one result per item,
// in the cycle after acceptance, at a sustained rate of one item per clock while
// the result side does not stall. A byte below 0x80 while idle starts a packet;
// nine body bytes with bit 7 set follow, and a byte below 0x80 among them
// aborts the packet and is dropped. On the tenth byte the checksum is worked out
// by a single adder tree and the bit 7 restoration is done in the same cycle,
// and packet_done and checksum_good mark that result. The stored packet is shown
// on every result. The output register decouples the two sides, so a byte is
// taken whenever the result register is empty or being emptied.
module msb_head_packet_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  mhpd_rx_if.sink     rx_i,
  mhpd_res_if.source  res_o
);
  import mhpd_pkg::*;

  logic                 in_packet_q, in_packet_d;
  count_t               taken_q, taken_d;
  count_t               remain_q, remain_d;
  byte_t  [PktLen-1:0]  store_q, store_d;
  logic                 done_d, good_d;
  logic                 accept;
  logic                 valid_q;
  fin_t                 fin;

  logic                 done_q, good_q;
  logic   [6:0]         id_q;
  byte_t  [PayloadLen-1:0] pay_q;

  assign rx_i.ready = !valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  mhpd_finish u_finish (
    .body_i (store_q[BodyLen-1:0]),
    .chk_i  (rx_i.rx_byte),
    .fin_o  (fin)
  );

  always_comb begin
    in_packet_d = in_packet_q;
    taken_d     = taken_q;
    remain_d    = remain_q;
    store_d     = store_q;
    done_d      = 1'b0;
    good_d      = 1'b0;
    if (in_packet_q) begin
      if (rx_i.rx_byte[7]) begin
        if (taken_q < count_t'(PktLen)) begin
          store_d[taken_q] = rx_i.rx_byte;
        end
        if (taken_q < CountMax) begin
          taken_d = taken_q + count_t'(1);
        end
        remain_d = remain_q - count_t'(1);
        if (remain_d == '0 && taken_d == count_t'(PktLen)) begin
          done_d      = 1'b1;
          good_d      = fin.good;
          in_packet_d = 1'b0;
          for (int unsigned k = 0; k < PayloadLen; k++) begin
            store_d[k+2] = fin.payload[k];
          end
        end
      end else begin
        in_packet_d = 1'b0;
      end
    end else if (!rx_i.rx_byte[7]) begin
      remain_d    = count_t'(BodyLen);
      taken_d     = count_t'(1);
      store_d[0]  = rx_i.rx_byte;
      in_packet_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      taken_q     <= '0;
      remain_q    <= '0;
      store_q     <= '0;
      valid_q     <= 1'b0;
    end else begin
      if (accept) begin
        in_packet_q <= in_packet_d;
        taken_q     <= taken_d;
        remain_q    <= remain_d;
        store_q     <= store_d;
        valid_q     <= 1'b1;
      end else if (res_o.ready) begin
        valid_q     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      done_q <= done_d;
      good_q <= good_d;
      id_q   <= store_d[0][6:0];
      for (int unsigned k = 0; k < PayloadLen; k++) begin
        pay_q[k] <= store_d[k+2];
      end
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.packet_done   = done_q;
  assign res_o.checksum_good = good_q;
  assign res_o.module_id     = id_q;
  assign res_o.payload_0     = pay_q[0];
  assign res_o.payload_1     = pay_q[1];
  assign res_o.payload_2     = pay_q[2];
  assign res_o.payload_3     = pay_q[3];
  assign res_o.payload_4     = pay_q[4];
  assign res_o.payload_5     = pay_q[5];
  assign res_o.payload_6     = pay_q[6];

  // A good checksum is only ever reported together with a completed packet.
  a_good_needs_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && good_q) |-> done_q)
    else $error("checksum_good without packet_done");

  // Inside a packet the taken and remaining counts always add up to ten.
  a_count_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_packet_q |-> ((taken_q + remain_q) == count_t'(PktLen)))
    else $error("packet counters out of step");

  // A completion always returns the deframer to idle.
  a_done_idles : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && done_d) |=> !in_packet_q)
    else $error("still in a packet after completion");

  // The state changes only when an item is accepted.
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ($stable(in_packet_q) && $stable(taken_q) && $stable(store_q)))
    else $error("deframer state changed without an item");

endmodule
